FILE: hdl/nmea_sentence_header_framer_top_defines.svh
// assertion helpers used by the framer module
`ifndef NMEA_SENTENCE_HEADER_FRAMER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_HEADER_FRAMER_TOP_DEFINES_SVH

// same-cycle implication on clk, off during rst
`define NSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, off during rst
`define NSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/nsf_pkg.sv
package nsf_pkg;

  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned HEADER_W            = 48;
  localparam int unsigned MAXLEN_W            = 7;
  localparam int unsigned CFG_IDX_W           = 2;
  localparam int unsigned HEADER_LEN          = 6;
  localparam int unsigned STORE_DEPTH_DEFAULT = 64;

  localparam logic [HEADER_W-1:0] HEADER_RESET   = 48'h4C4C474E4724;
  localparam logic [BYTE_W-1:0]   SENTINEL_RESET = 8'd114;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET   = 7'd56;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENTINEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN   = 2'd2;

  typedef struct packed {
    logic [HEADER_W-1:0] header_bytes;
    logic [BYTE_W-1:0]   sentinel_char;
    logic [MAXLEN_W-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  function automatic logic [BYTE_W-1:0] header_char(input logic [HEADER_W-1:0] hdr,
                                                    input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      3'd0:    c = hdr[7:0];
      3'd1:    c = hdr[15:8];
      3'd2:    c = hdr[23:16];
      3'd3:    c = hdr[31:24];
      3'd4:    c = hdr[39:32];
      3'd5:    c = hdr[47:40];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/nsf_cfg_if.sv
interface nsf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [nsf_pkg::CFG_IDX_W-1:0]    index;
  logic [nsf_pkg::HEADER_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/nsf_rx_if.sv
interface nsf_rx_if;
  logic                       valid;
  logic                       ready;
  logic [nsf_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, rx_byte, input ready);
  modport sink   (input valid, rx_byte, output ready);
endinterface

FILE: hdl/nsf_msg_if.sv
interface nsf_msg_if;
  logic                       valid;
  logic                       ready;
  logic [nsf_pkg::BYTE_W-1:0] msg_byte;
  logic                       msg_last;

  modport source (output valid, msg_byte, msg_last, input ready);
  modport sink   (input valid, msg_byte, msg_last, output ready);
endinterface

FILE: hdl/nmea_sentence_header_framer_top.sv
// channel  role   payload                     transaction when
// cfg      sink   index[1:0], data[47:0]      cfg.valid && cfg.ready
// rx       sink   rx_byte[7:0]                rx.valid && rx.ready
// msg      source msg_byte[7:0], msg_last     msg.valid && msg.ready
//
// a received byte is taken while the framer is idle; rx.ready stays high between messages
// a completed message is read from the line store with one memory read and
// one output load per byte, with rx held off meanwhile
// a stalled msg sink stretches the readout; the last byte waits in the output
// register while the next byte is taken
// rst clears position, body flag and registers to defaults; the store is not cleared
module nmea_sentence_header_framer_top #(
  parameter int unsigned STORE_DEPTH = nsf_pkg::STORE_DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  nsf_cfg_if.sink     cfg,
  nsf_rx_if.sink      rx,
  nsf_msg_if.source   msg
);
  import nsf_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  cfg_t              regs;
  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  nsf_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  nsf_line_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  nsf_framer #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_framer (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .rx        (rx),
    .msg       (msg),
    .mem_ctl   (mem_ctl),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

FILE: hdl/nsf_cfg_regs.sv
module nsf_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  nsf_cfg_if.sink       cfg,
  output nsf_pkg::cfg_t regs
);
  import nsf_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.header_bytes  <= HEADER_RESET;
      regs.sentinel_char <= SENTINEL_RESET;
      regs.max_length    <= MAXLEN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_HEADER:   regs.header_bytes  <= cfg.data;
        CFG_SENTINEL: regs.sentinel_char <= cfg.data[BYTE_W-1:0];
        CFG_MAXLEN:   regs.max_length    <= cfg.data[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/nsf_line_mem.sv
module nsf_line_mem #(
  parameter int unsigned DEPTH = nsf_pkg::STORE_DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  nsf_pkg::mem_ctl_t          ctl,
  input  logic [AW-1:0]              waddr,
  input  logic [nsf_pkg::BYTE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [nsf_pkg::BYTE_W-1:0] rdata
);
  import nsf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/nsf_framer.sv
`include "nmea_sentence_header_framer_top_defines.svh"

module nsf_framer #(
  parameter int unsigned STORE_DEPTH = nsf_pkg::STORE_DEPTH_DEFAULT,
  parameter int unsigned AW          = $clog2(STORE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  nsf_pkg::cfg_t              regs,
  nsf_rx_if.sink                     rx,
  nsf_msg_if.source                  msg,
  output nsf_pkg::mem_ctl_t          mem_ctl,
  output logic [AW-1:0]              mem_waddr,
  output logic [nsf_pkg::BYTE_W-1:0] mem_wdata,
  output logic [AW-1:0]              mem_raddr,
  input  logic [nsf_pkg::BYTE_W-1:0] mem_rdata
);
  import nsf_pkg::*;

  localparam int unsigned PW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned LW = (PW > MAXLEN_W) ? PW : MAXLEN_W;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_RD_ADDR = 3'b010,
    S_RD_DATA = 3'b100
  } state_t;

  state_t        state;
  logic [PW-1:0] pos;
  logic          in_body;
  logic [PW-1:0] count;
  logic [AW-1:0] rd_ptr;
  logic          out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic          out_last;

  logic          in_acc;
  logic          hdr_match;
  logic          take;
  logic          is_sent;
  logic [PW-1:0] pos_inc;
  logic [LW-1:0] depth_lw;
  logic [LW-1:0] max_lw;
  logic [LW-1:0] limit;
  logic          at_limit;
  logic          out_free;
  logic          load;
  logic          rd_last;

  assign rx.ready     = (state == S_IDLE);
  assign in_acc       = rx.valid && rx.ready;
  assign hdr_match    = (pos < PW'(HEADER_LEN)) &&
                        (rx.rx_byte == header_char(regs.header_bytes, pos[2:0]));
  assign take         = in_body || hdr_match;
  assign is_sent      = (rx.rx_byte == regs.sentinel_char);
  assign pos_inc      = pos + PW'(1);
  assign depth_lw     = LW'(STORE_DEPTH);
  assign max_lw       = LW'(regs.max_length);
  assign limit        = (max_lw > depth_lw) ? depth_lw : max_lw;
  assign at_limit     = (LW'(pos_inc) >= limit);

  assign out_free     = !out_valid || msg.ready;
  assign load         = (state == S_RD_DATA) && out_free;
  assign rd_last      = ((PW'(rd_ptr) + PW'(1)) == count);

  assign mem_ctl.we   = in_acc && take;
  assign mem_ctl.re   = (state == S_RD_ADDR);
  assign mem_waddr    = pos[AW-1:0];
  assign mem_wdata    = rx.rx_byte;
  assign mem_raddr    = rd_ptr;

  assign msg.valid    = out_valid;
  assign msg.msg_byte = out_byte;
  assign msg.msg_last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      in_body <= 1'b0;
      count   <= '0;
      rd_ptr  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (!take) begin
              pos <= '0;
            end else if (is_sent) begin
              count   <= pos_inc;
              rd_ptr  <= '0;
              pos     <= '0;
              in_body <= 1'b0;
              state   <= S_RD_ADDR;
            end else if (at_limit) begin
              pos     <= '0;
              in_body <= 1'b0;
            end else begin
              pos <= pos_inc;
              if (pos_inc == PW'(HEADER_LEN)) begin
                in_body <= 1'b1;
              end
            end
          end
        end
        S_RD_ADDR: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          if (out_free) begin
            rd_ptr <= rd_ptr + AW'(1);
            state  <= rd_last ? S_IDLE : S_RD_ADDR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register, frees the readout from the sink
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (msg.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= mem_rdata;
      out_last <= rd_last;
    end
  end

  `NSF_ASSERT_NOW(a_body_pos, in_body, pos >= PW'(HEADER_LEN), "body flag without full header")
  `NSF_ASSERT_NOW(a_hdr_pos, !in_body, pos < PW'(HEADER_LEN), "header position out of range")
  `NSF_ASSERT_NOW(a_pos_depth, 1'b1, pos < PW'(STORE_DEPTH), "write position past store")
  `NSF_ASSERT_NOW(a_rd_range, state != S_IDLE, PW'(rd_ptr) < count, "readout past message end")
  `NSF_ASSERT_NEXT(a_last_idle, load && rd_last, state == S_IDLE, "readout did not finish")

endmodule
